[rtl/core/bpfa_pkg.sv]
// Package for the bitmap page frame allocator: commands, status codes,
// sequencer states and the word unit request/response types. No dependencies.
package bpfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_MARK_FREE = 2'd0,
        CMD_MARK_USED = 2'd1,
        CMD_ALLOC     = 2'd2,
        CMD_FREE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_OOM         = 2'd1,
        STS_DOUBLE_FREE = 2'd2,
        STS_RANGE       = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_A_SET,
        ST_M_RD,
        ST_M_WR,
        ST_F_RD,
        ST_F_WR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        WU_RANGE_CLR,
        WU_RANGE_SET,
        WU_ALLOC,
        WU_BIT_CLR
    } t_wu_op;

    typedef struct packed {
        t_wu_op           op;
        logic             first;
        logic             last;
        logic [BIT_W-1:0] lo_bit;
        logic [BIT_W-1:0] hi_bit;
        logic [BIT_W-1:0] bit_sel;
    } t_wu_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] wdata;
        logic                 all_ones;
        logic                 bit_val;
        logic [BIT_W-1:0]     first_zero;
    } t_wu_rsp;

endpackage

[rtl/core/bitmap_page_frame_allocator_unit.sv]
// Bitmap page frame allocator, first fit: one used bit per page in a word RAM,
// a saturating free count. Depends on bpfa_pkg, bpfa_ram, bpfa_word_unit.
//
// After reset a clearing pass writes zero to every bitmap word, one word per
// cycle ((MAX_PAGES+31)/32 words, 1024 at defaults); input is not taken until
// it ends. One command is processed at a time. Alloc scans the bitmap one
// 32-bit word per cycle through the RAM read port. Mark free/used does a
// read-modify-write of each word the region touches. Free page reads the
// word, then clears the bit unless it was already free; an empty region or an
// out-of-range free goes straight to the result. The result sits in an
// output register so the next word can be accepted while it waits.
module bitmap_page_frame_allocator_unit
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_region_start,
    input  logic [31:0] i_region_end,
    input  logic [31:0] i_page_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_page_address,
    output logic [1:0]  o_status,
    output logic [15:0] o_free_count
);

    localparam int BMP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (BMP_WORDS > 1) ? $clog2(BMP_WORDS) : 1;
    localparam int IW        = $clog2(MAX_PAGES + 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(BMP_WORDS - 1);
    localparam logic [AW:0]   END_PTR   = (AW + 1)'(BMP_WORDS);
    localparam logic [31:0]   MAX32     = 32'(MAX_PAGES);

    t_state               r_state, n_state;
    logic [AW:0]          r_ptr, n_ptr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_pidx, n_pidx;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [AW-1:0]        r_widx, n_widx;
    t_cmd                 r_cmd, n_cmd;
    logic [IW-1:0]        r_lo, n_lo;
    logic [IW-1:0]        r_hi_m1, n_hi_m1;
    logic [IW-1:0]        r_n, n_n;
    logic [COUNT_W-1:0]   r_free, n_free;
    logic [15:0]          r_total;
    logic [31:0]          r_res_addr, n_res_addr;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_addr, n_out_addr;
    t_status              r_out_status, n_out_status;
    logic [COUNT_W-1:0]   r_out_free, n_out_free;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    t_wu_req              wu_req;
    t_wu_rsp              wu_rsp;
    logic [WORD_BITS-1:0] wu_word;

    logic                 accept, out_free;
    t_cmd                 in_cmd;
    logic [31:0]          in_lo, in_re_pg, in_hi, in_hi_m1, in_n, in_pg, limit32;
    logic [31:0]          in_lo_w, in_pg_w;
    logic [IW-1:0]        lo_w_full, hi_w_full;
    logic [AW-1:0]        lo_wi, hi_wi;
    logic                 is_last;
    logic [31:0]          free32, n32, sum32;
    logic [COUNT_W-1:0]   up_val, down_val;
    logic [31:0]          p32;
    logic                 p_ok;

    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_cmd     = t_cmd'(i_command);

    assign in_lo    = i_region_start >> PAGE_SHIFT;
    assign in_re_pg = i_region_end >> PAGE_SHIFT;
    assign in_hi    = (in_re_pg > MAX32) ? MAX32 : in_re_pg;
    assign in_hi_m1 = in_hi - 32'd1;
    assign in_n     = in_hi - in_lo;
    assign in_pg    = i_page_addr >> PAGE_SHIFT;
    assign in_lo_w  = in_lo >> BIT_W;
    assign in_pg_w  = in_pg >> BIT_W;
    assign limit32  = ({16'd0, r_total} > MAX32) ? MAX32 : {16'd0, r_total};

    assign lo_w_full = r_lo >> BIT_W;
    assign hi_w_full = r_hi_m1 >> BIT_W;
    assign lo_wi     = lo_w_full[AW-1:0];
    assign hi_wi     = hi_w_full[AW-1:0];
    assign is_last   = (r_ptr[AW-1:0] == hi_wi);

    assign free32   = {16'd0, r_free};
    assign n32      = 32'(r_n);
    assign sum32    = free32 + n32;
    assign up_val   = (sum32 > {16'd0, COUNT_MAX}) ? COUNT_MAX : sum32[COUNT_W-1:0];
    assign down_val = (free32 > n32) ? COUNT_W'(free32 - n32) : '0;

    assign p32  = (32'(r_widx) << BIT_W) | 32'(wu_rsp.first_zero);
    assign p_ok = (p32 < limit32);

    assign wu_word = (r_state == ST_A_SET) ? r_word : ram_rdata;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BMP_WORDS),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bpfa_word_unit u_wu (
        .i_req (wu_req),
        .i_word(wu_word),
        .o_rsp (wu_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_ptr[AW-1:0] == LAST_WORD) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_ALLOC: n_state = ST_SCAN;
                        CMD_FREE:  n_state = (in_pg >= limit32) ? ST_DONE : ST_F_RD;
                        default:   n_state = (in_lo >= in_hi) ? ST_DONE : ST_M_RD;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_pend && !wu_rsp.all_ones) begin
                    n_state = ST_A_SET;
                end else if (r_pend && (r_pidx == LAST_WORD)) begin
                    n_state = ST_DONE;
                end
            end
            ST_A_SET: n_state = ST_DONE;
            ST_M_RD:  n_state = ST_M_WR;
            ST_M_WR:  n_state = is_last ? ST_DONE : ST_M_RD;
            ST_F_RD:  n_state = ST_F_WR;
            ST_F_WR:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_CLR;
        endcase
    end

    // RAM and word unit controls
    always_comb begin
        ram_we         = 1'b0;
        ram_waddr      = r_ptr[AW-1:0];
        ram_wdata      = wu_rsp.wdata;
        ram_re         = 1'b0;
        ram_raddr      = r_ptr[AW-1:0];
        wu_req.op      = (r_cmd == CMD_MARK_USED) ? WU_RANGE_SET : WU_RANGE_CLR;
        wu_req.first   = (r_ptr[AW-1:0] == lo_wi);
        wu_req.last    = is_last;
        wu_req.lo_bit  = r_lo[BIT_W-1:0];
        wu_req.hi_bit  = r_hi_m1[BIT_W-1:0];
        wu_req.bit_sel = r_lo[BIT_W-1:0];
        case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_SCAN: begin
                ram_re    = (r_ptr < END_PTR);
                wu_req.op = WU_ALLOC;
            end
            ST_A_SET: begin
                wu_req.op = WU_ALLOC;
                ram_we    = p_ok;
                ram_waddr = r_widx;
            end
            ST_M_RD, ST_F_RD: begin
                ram_re = 1'b1;
            end
            ST_M_WR: begin
                ram_we = 1'b1;
            end
            ST_F_WR: begin
                wu_req.op = WU_BIT_CLR;
                ram_we    = wu_rsp.bit_val;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_ptr        = r_ptr;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_word       = r_word;
        n_widx       = r_widx;
        n_cmd        = r_cmd;
        n_lo         = r_lo;
        n_hi_m1      = r_hi_m1;
        n_n          = r_n;
        n_free       = r_free;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_free   = r_out_free;
        case (r_state)
            ST_CLR: begin
                n_ptr = r_ptr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd        = in_cmd;
                    n_pend       = 1'b0;
                    n_res_addr   = '0;
                    n_res_status = STS_OK;
                    n_n          = IW'(1);
                    case (in_cmd)
                        CMD_ALLOC: begin
                            n_ptr = '0;
                        end
                        CMD_FREE: begin
                            n_lo  = in_pg[IW-1:0];
                            n_ptr = (AW + 1)'(in_pg_w[AW-1:0]);
                            if (in_pg >= limit32) n_res_status = STS_RANGE;
                        end
                        default: begin
                            n_lo    = in_lo[IW-1:0];
                            n_hi_m1 = in_hi_m1[IW-1:0];
                            n_n     = in_n[IW-1:0];
                            n_ptr   = (AW + 1)'(in_lo_w[AW-1:0]);
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_pend = ram_re;
                if (ram_re) begin
                    n_pidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + 1'b1;
                end
                if (r_pend && !wu_rsp.all_ones) begin
                    n_word = ram_rdata;
                    n_widx = r_pidx;
                end else if (r_pend && (r_pidx == LAST_WORD)) begin
                    n_res_status = STS_OOM;
                end
            end
            ST_A_SET: begin
                if (p_ok) begin
                    n_res_addr = p32 << PAGE_SHIFT;
                    n_free     = down_val;
                end else begin
                    n_res_status = STS_OOM;
                end
            end
            ST_M_WR: begin
                n_ptr = r_ptr + 1'b1;
                if (is_last) begin
                    n_free = (r_cmd == CMD_MARK_USED) ? down_val : up_val;
                end
            end
            ST_F_WR: begin
                if (wu_rsp.bit_val) begin
                    n_free = up_val;
                end else begin
                    n_res_status = STS_DOUBLE_FREE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_out_free   = r_free;
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_free      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_total <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_word       <= n_word;
        r_widx       <= n_widx;
        r_cmd        <= n_cmd;
        r_lo         <= n_lo;
        r_hi_m1      <= n_hi_m1;
        r_n          <= n_n;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;
    assign o_free_count   = r_out_free;

endmodule

[rtl/core/bpfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpfa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/core/bpfa_word_unit.sv]
// Shared bitmap word unit: range/bit mask build, set/clear, first-zero search.
// Depends on bpfa_pkg.
module bpfa_word_unit
    import bpfa_pkg::*;
(
    input  t_wu_req              i_req,
    input  logic [WORD_BITS-1:0] i_word,
    output t_wu_rsp              o_rsp
);

    logic [WORD_BITS-1:0] mask_lo;
    logic [WORD_BITS-1:0] mask_hi;
    logic [WORD_BITS-1:0] mask;
    logic [BIT_W-1:0]     fz;
    logic [BIT_W-1:0]     bit_sel;

    always_comb begin
        fz = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                fz = BIT_W'(b);
            end
        end
    end

    always_comb begin
        mask_lo = i_req.first ? ({WORD_BITS{1'b1}} << i_req.lo_bit) : {WORD_BITS{1'b1}};
        mask_hi = i_req.last ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - i_req.hi_bit))
                             : {WORD_BITS{1'b1}};
        bit_sel = (i_req.op == WU_ALLOC) ? fz : i_req.bit_sel;
        mask    = '0;
        o_rsp   = '0;
        case (i_req.op)
            WU_RANGE_CLR: begin
                mask        = mask_lo & mask_hi;
                o_rsp.wdata = i_word & ~mask;
            end
            WU_RANGE_SET: begin
                mask        = mask_lo & mask_hi;
                o_rsp.wdata = i_word | mask;
            end
            WU_ALLOC: begin
                mask        = WORD_BITS'(1) << bit_sel;
                o_rsp.wdata = i_word | mask;
            end
            WU_BIT_CLR: begin
                mask        = WORD_BITS'(1) << bit_sel;
                o_rsp.wdata = i_word & ~mask;
            end
            default: begin
                o_rsp.wdata = i_word;
            end
        endcase
        o_rsp.all_ones   = &i_word;
        o_rsp.bit_val    = i_word[bit_sel];
        o_rsp.first_zero = fz;
    end

endmodule

[rtl/core/bpfa_checker.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_unit.
module bpfa_checker
    import bpfa_pkg::*;
#(
    parameter int PAGE_SHIFT = 12
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_page_address,
    input logic [1:0]  o_status,
    input logic [15:0] o_free_count
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_page_address)
            && $stable(o_status) && $stable(o_free_count))
        else $error("result word changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STS_OK) |-> (o_page_address == 32'd0))
        else $error("nonzero address on failed command");

    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_page_address[PAGE_SHIFT-1:0] == '0))
        else $error("allocated address not page aligned");

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker #(.PAGE_SHIFT(PAGE_SHIFT)) u_bpfa_checker (.*);

[tb/sv/bitmap_page_frame_allocator_unit_tb.sv]
// Testbench for bitmap_page_frame_allocator_unit: directed table plus random commands.
// Typed rows are checked on table words, others on an in-bench first-fit bitmap model.
// Depends on bpfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_unit_tb;
    import bpfa_pkg::*;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int MAP_WORDS  = (MAX_PAGES + 31) / 32;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] addr;
        t_status     sts;
        logic [15:0] cnt;
    } t_frame_rsp;

    typedef struct {
        int          limit;
        t_cmd        cmd;
        logic [31:0] rs;
        logic [31:0] re;
        logic [31:0] pa;
        bit          typed;
        t_frame_rsp  want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [31:0] i_region_start;
    logic [31:0] i_region_end;
    logic [31:0] i_page_addr;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_page_address;
    logic [1:0]  o_status;
    logic [15:0] o_free_count;

    logic [31:0] used_map [MAP_WORDS];
    logic [15:0] free_cnt;
    logic [15:0] page_limit;
    t_frame_rsp  frame_rsp_q [$];
    logic [31:0] live_pages [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int fail_cnt    = 0;
    int word_cnt    = 0;
    int sts_cnt [4] = '{0, 0, 0, 0};

    // limit -1 keeps the register
    t_dir_row dir_rows [26] = '{
        '{-1,    CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0,         STS_OOM,         16'd0}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0,         STS_RANGE,       16'd0}},
        '{64,    CMD_MARK_FREE, 32'h0,         32'h0004_0000, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd64}},
        '{-1,    CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd63}},
        '{-1,    CMD_ALLOC,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, '{32'h0000_1000, STS_OK,          16'd62}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h0000_0FFF,
          1'b1, '{32'h0,         STS_OK,          16'd63}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0,         STS_DOUBLE_FREE, 16'd63}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h0004_0000,
          1'b1, '{32'h0,         STS_RANGE,       16'd63}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'hFFFF_FFFF,
          1'b1, '{32'h0,         STS_RANGE,       16'd63}},
        '{-1,    CMD_MARK_USED, 32'hFFFF_F000, 32'h0,         32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd63}},
        '{-1,    CMD_MARK_USED, 32'h0,         32'h0004_0000, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd0}},
        '{-1,    CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0,         STS_OOM,         16'd0}},
        '{32768, CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0004_0000, STS_OK,          16'd0}},
        '{-1,    CMD_MARK_FREE, 32'h0,         32'hFFFF_FFFF, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd32768}},
        '{-1,    CMD_MARK_FREE, 32'h0000_0ABC, 32'hFFFF_FFFF, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd65535}},
        '{-1,    CMD_MARK_FREE, 32'h0800_0000, 32'hFFFF_FFFF, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd65535}},
        '{-1,    CMD_MARK_USED, 32'h07FF_F000, 32'h0900_0000, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd65534}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h07FF_F000,
          1'b1, '{32'h0,         STS_OK,          16'd65535}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h07FF_FFFF,
          1'b1, '{32'h0,         STS_DOUBLE_FREE, 16'd65535}},
        '{-1,    CMD_FREE,      32'h0,         32'h0,         32'h0800_0000,
          1'b1, '{32'h0,         STS_RANGE,       16'd65535}},
        '{-1,    CMD_MARK_USED, 32'h0,         32'hFFFF_F000, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd32767}},
        '{-1,    CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b1, '{32'h0,         STS_OOM,         16'd32767}},
        '{-1,    CMD_MARK_FREE, 32'h07FF_F000, 32'h0800_0000, 32'h0,
          1'b1, '{32'h0,         STS_OK,          16'd32768}},
        '{-1,    CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b1, '{32'h07FF_F000, STS_OK,          16'd32767}},
        '{-1,    CMD_MARK_USED, 32'h0000_5123, 32'h0002_0ABC, 32'h0,
          1'b0, '{32'h0,         STS_OK,          16'd0}},
        '{-1,    CMD_ALLOC,     32'h0,         32'h0,         32'h0,
          1'b0, '{32'h0,         STS_OK,          16'd0}}
    };

    bitmap_page_frame_allocator_unit #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_region_start (i_region_start),
        .i_region_end   (i_region_end),
        .i_page_addr    (i_page_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_page_address (o_page_address),
        .o_status       (o_status),
        .o_free_count   (o_free_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_frame_rsp frame_cmd_apply(t_cmd cmd, logic [31:0] rs,
                                                   logic [31:0] re, logic [31:0] pa);
        t_frame_rsp  r;
        int unsigned lim;
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        int unsigned sum;
        bit          found;
        r = '{32'h0, STS_OK, 16'd0};
        lim = (page_limit > MAX_PAGES) ? MAX_PAGES : page_limit;
        found = 1'b0;
        p = 0;
        case (cmd)
            CMD_MARK_FREE, CMD_MARK_USED: begin
                lo = rs >> PAGE_SHIFT;
                hi = re >> PAGE_SHIFT;
                if (hi > MAX_PAGES) hi = MAX_PAGES;
                if (lo < hi) begin
                    for (int unsigned q = lo; q < hi; q++)
                        used_map[q >> 5][q % 32] = (cmd == CMD_MARK_USED);
                    if (cmd == CMD_MARK_USED) begin
                        free_cnt = (free_cnt > hi - lo) ? free_cnt - 16'(hi - lo) : 16'd0;
                    end else begin
                        sum = free_cnt + (hi - lo);
                        free_cnt = (sum > COUNT_MAX) ? COUNT_MAX : 16'(sum);
                    end
                end
            end
            CMD_ALLOC: begin
                for (int w = 0; w < MAP_WORDS && !found; w++) begin
                    if (used_map[w] != 32'hFFFF_FFFF) begin
                        for (int b = 0; b < 32 && !found; b++) begin
                            if (!used_map[w][b]) begin
                                p = w * 32 + b;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (found && p < lim) begin
                    used_map[p >> 5][p % 32] = 1'b1;
                    if (free_cnt != 0) free_cnt = free_cnt - 16'd1;
                    r.addr = 32'(p << PAGE_SHIFT);
                end else begin
                    r.sts = STS_OOM;
                end
            end
            default: begin
                p = pa >> PAGE_SHIFT;
                if (p >= lim) begin
                    r.sts = STS_RANGE;
                end else if (!used_map[p >> 5][p % 32]) begin
                    r.sts = STS_DOUBLE_FREE;
                end else begin
                    used_map[p >> 5][p % 32] = 1'b0;
                    if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 16'd1;
                end
            end
        endcase
        r.cnt = free_cnt;
        return r;
    endfunction

    // entered and left at a falling edge; valid stays up until the word is taken
    task automatic push_word(t_cmd cmd, logic [31:0] rs, logic [31:0] re,
                             logic [31:0] pa, bit typed, t_frame_rsp want);
        t_frame_rsp r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_region_start <= rs;
        i_region_end   <= re;
        i_page_addr    <= pa;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = frame_cmd_apply(cmd, rs, re, pa);
        if (typed) r = want;
        if (cmd == CMD_ALLOC && r.sts == STS_OK) live_pages.push_back(r.addr);
        frame_rsp_q.push_back(r);
        word_cnt++;
        @(negedge i_clk);
    endtask

    task automatic drain_rsp();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (frame_rsp_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_page_limit(logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        page_limit = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_random(int unsigned win);
        t_cmd        cmd;
        logic [31:0] rs;
        logic [31:0] re;
        logic [31:0] pa;
        int unsigned roll;
        int unsigned lo;
        int          k;
        roll = $urandom_range(99);
        rs = $urandom;
        re = $urandom;
        pa = $urandom;
        if (roll < 8) begin
            cmd = t_cmd'($urandom_range(3));
        end else if (roll < 10) begin
            // region running past the end of the bitmap
            cmd = t_cmd'($urandom_range(1));
            rs  = $urandom_range(32'h0000_3FFF);
            re  = re | 32'h8000_0000;
        end else if (roll < 45) begin
            cmd = CMD_ALLOC;
        end else if (roll < 75) begin
            cmd = CMD_FREE;
            if (live_pages.size() != 0 && $urandom_range(2) != 0) begin
                k  = $urandom_range(live_pages.size() - 1);
                pa = live_pages[k] | $urandom_range(4095);
                live_pages.delete(k);
            end else begin
                pa = ($urandom_range(win - 1) << PAGE_SHIFT) | $urandom_range(4095);
            end
        end else begin
            cmd = (roll < 88) ? CMD_MARK_FREE : CMD_MARK_USED;
            lo  = $urandom_range(win - 1);
            rs  = (lo << PAGE_SHIFT) | $urandom_range(4095);
            re  = ((lo + $urandom_range(70)) << PAGE_SHIFT) | $urandom_range(4095);
        end
        push_word(cmd, rs, re, pa, 1'b0, '0);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, logic [15:0] lim, int n_words,
                             int drain_at, int hold_at);
        int unsigned win;
        drain_rsp();
        set_page_limit(lim);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        win = (lim + 32 > MAX_PAGES) ? MAX_PAGES : lim + 32;
        for (int i = 0; i < n_words; i++) begin
            if (i == drain_at) drain_rsp();
            if (i == hold_at) hold_req++;
            push_random(win);
        end
    endtask

    initial begin : rx_drive
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_frame_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_rsp_q.size() == 0) begin
                $display("%0t: unexpected word addr %h status %0d count %0d",
                         $time, o_page_address, o_status, o_free_count);
                fail_cnt++;
            end else begin
                want = frame_rsp_q.pop_front();
                sts_cnt[want.sts]++;
                if (o_page_address !== want.addr) begin
                    $display("%0t: page_address exp %h got %h", $time, want.addr,
                             o_page_address);
                    fail_cnt++;
                end
                if (o_status !== want.sts) begin
                    $display("%0t: status exp %0d got %0d", $time, want.sts, o_status);
                    fail_cnt++;
                end
                if (o_free_count !== want.cnt) begin
                    $display("%0t: free_count exp %0d got %0d", $time, want.cnt,
                             o_free_count);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : stim
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 16'd0;
        i_in_valid     = 1'b0;
        i_command      = CMD_MARK_FREE;
        i_region_start = 32'd0;
        i_region_end   = 32'd0;
        i_page_addr    = 32'd0;
        foreach (used_map[w]) used_map[w] = 32'd0;
        free_cnt   = 16'd0;
        page_limit = 16'd0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].limit >= 0) begin
                drain_rsp();
                set_page_limit(16'(dir_rows[i].limit));
            end
            push_word(dir_rows[i].cmd, dir_rows[i].rs, dir_rows[i].re, dir_rows[i].pa,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(30, 63, 16'($urandom_range(32, 256)), 185, 90, -1);
        run_phase(63, 30, 16'($urandom_range(257, 4096)), 185, -1, -1);
        run_phase(0, 0, 16'd32768, 185, -1, 60);

        drain_rsp();
        repeat (2100) @(negedge i_clk);
        $display("Ran %0d command words (26 directed) over page limits 0, 64, 32768 and two",
                 word_cnt);
        $display("random ones: ok %0d, out of memory %0d, double free %0d, ignored %0d",
                 sts_cnt[STS_OK], sts_cnt[STS_OOM], sts_cnt[STS_DOUBLE_FREE],
                 sts_cnt[STS_RANGE]);
        if (fail_cnt == 0) begin
            $display("PASS bitmap_page_frame_allocator_unit");
        end else begin
            $display("FAIL bitmap_page_frame_allocator_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("%0t: timeout, %0d words still outstanding", $time, frame_rsp_q.size());
        $display("FAIL bitmap_page_frame_allocator_unit");
        $finish;
    end

endmodule

[files.f]
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_ram.sv
rtl/core/bpfa_word_unit.sv
rtl/core/bitmap_page_frame_allocator_unit.sv
rtl/core/bpfa_checker.sv
tb/sv/bitmap_page_frame_allocator_unit_tb.sv
